[rtl/core/usb_device_threat_table_top_assert.svh]
// Assertion macros shared by the threat table RTL.
`ifndef USB_DEVICE_THREAT_TABLE_TOP_ASSERT_SVH
`define USB_DEVICE_THREAT_TABLE_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside of reset.
`define UDTT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("threat table assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define UDTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("threat table assertion failed");

`endif

[rtl/core/udtt_pkg.sv]
// ----------------------------------------------------------------------------
// udtt_pkg
// Types, codes and the classification rule of the USB device threat table.
// ----------------------------------------------------------------------------
package udtt_pkg;

  localparam int unsigned ENTRIES_DEF = 4;

  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned PROTO_W  = 8;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned COUNT_W  = 32;

  localparam logic [RATE_W-1:0] THRESH_RESET = RATE_W'(20);
  localparam logic [PROTO_W-1:0] PROTO_MOUSE = PROTO_W'(2);

  localparam logic [LEVEL_W-1:0] LVL_SAFE      = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_UNSAFE    = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_MALICIOUS = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_UPDATE   = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_ACTIVITY = 3'd3,
    OP_QUERY    = 3'd4
  } op_e;

  // Request fields, last member in the lowest bits.
  typedef struct packed {
    logic               live_is_hid;
    logic [RATE_W-1:0]  rate;
    logic               mounted;
    logic [PROTO_W-1:0] hid_proto;
    logic               is_hid;
    logic [ADDR_W-1:0]  usb_addr;
    logic [2:0]         operation;
  } req_t;

  typedef struct packed {
    logic               table_full;
    logic [COUNT_W-1:0] report_count;
    logic [LEVEL_W-1:0] risk_level;
    logic               found;
  } rsp_t;

  localparam int unsigned REQ_W      = $bits(req_t);
  localparam int unsigned RSP_W      = $bits(rsp_t);
  localparam int unsigned REQ_DATA_W = ((REQ_W + 7) / 8) * 8;
  localparam int unsigned RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

  function automatic logic [LEVEL_W-1:0] classify(input logic hid,
                                                  input logic [PROTO_W-1:0] proto);
    logic [LEVEL_W-1:0] lvl;
    lvl = LVL_SAFE;
    if (hid && (proto != PROTO_MOUSE)) begin
      lvl = LVL_UNSAFE;
    end
    return lvl;
  endfunction

endpackage

[rtl/core/usb_device_threat_table_top.sv]
// ----------------------------------------------------------------------------
// usb_device_threat_table_top
// Table of tracked USB devices with add, update, remove, activity and query.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake             Content
//  s_axis    in   tvalid/tready         request: op, address, device info, rate
//  m_axis    out  tvalid/tready         response: found, level, count, full
//  cfg       in   cfg_we_i (no wait)    rate threshold
//
//  A request is held in the input register; the table lookup, slot update and
//  response are formed from it combinationally and registered at the output,
//  so one request per cycle is sustained while m_axis_tready stays high.
//  Reset clears all slots at once and loads a threshold of 20.
//  A stalled response holds the input register; s_axis_tready drops only
//  when both registers are full and m_axis_tready is low.
// ----------------------------------------------------------------------------
`include "usb_device_threat_table_top_assert.svh"

module usb_device_threat_table_top
  import udtt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RATE_W-1:0]     cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // operation, usb_addr, is_hid, hid_proto, mounted, rate, live_is_hid
  input  logic [REQ_DATA_W-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // found, risk_level, report_count, table_full
  output logic [RSP_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic              in_valid_q;
  req_t              in_q;
  logic              out_valid_q;
  rsp_t              out_q, out_d;
  logic              advance;
  logic [RATE_W-1:0] thresh_q;

  logic [ENTRIES-1:0]              mounted_q, mounted_d;
  logic [ENTRIES-1:0][ADDR_W-1:0]  addr_q, addr_d;
  logic [ENTRIES-1:0]              hid_q, hid_d;
  logic [ENTRIES-1:0][PROTO_W-1:0] proto_q, proto_d;
  logic [ENTRIES-1:0][LEVEL_W-1:0] level_q, level_d;
  logic [ENTRIES-1:0][COUNT_W-1:0] reports_q, reports_d;
  logic [ENTRIES-1:0][RATE_W-1:0]  rate_q, rate_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = RSP_DATA_W'(out_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      thresh_q    <= THRESH_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= req_t'(s_axis_tdata[REQ_W-1:0]);
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mounted_q <= '0;
      addr_q    <= '0;
      hid_q     <= '0;
      proto_q   <= '0;
      level_q   <= '0;
      reports_q <= '0;
      rate_q    <= '0;
    end else if (advance) begin
      mounted_q <= mounted_d;
      addr_q    <= addr_d;
      hid_q     <= hid_d;
      proto_q   <= proto_d;
      level_q   <= level_d;
      reports_q <= reports_d;
      rate_q    <= rate_d;
    end
  end

  // Lookup and slot update for the request in the input register.
  logic               match_hit, free_hit, rm_hit, do_add;
  logic [IdxW-1:0]    match_idx, free_idx, rm_idx;
  logic [LEVEL_W-1:0] cls, act_lvl;
  logic               act_hid;
  logic [COUNT_W-1:0] act_cnt;

  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    rm_hit    = 1'b0;
    rm_idx    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!match_hit && mounted_q[i] && (addr_q[i] == in_q.usb_addr)) begin
        match_hit = 1'b1;
        match_idx = IdxW'(i);
      end
      if (!free_hit && !mounted_q[i]) begin
        free_hit = 1'b1;
        free_idx = IdxW'(i);
      end
      if (!rm_hit && (addr_q[i] == in_q.usb_addr)) begin
        rm_hit = 1'b1;
        rm_idx = IdxW'(i);
      end
    end

    cls     = classify(in_q.is_hid, in_q.hid_proto);
    act_lvl = level_q[match_idx];
    act_hid = hid_q[match_idx];
    act_cnt = reports_q[match_idx] + COUNT_W'(1);
    // Promote a device that turns out to be HID, then escalate on rate.
    if (!hid_q[match_idx] && in_q.live_is_hid) begin
      act_hid = 1'b1;
      if (act_lvl < LVL_UNSAFE) begin
        act_lvl = LVL_UNSAFE;
      end
    end
    if (in_q.rate > thresh_q) begin
      act_lvl = LVL_MALICIOUS;
    end

    mounted_d = mounted_q;
    addr_d    = addr_q;
    hid_d     = hid_q;
    proto_d   = proto_q;
    level_d   = level_q;
    reports_d = reports_q;
    rate_d    = rate_q;
    out_d     = '0;
    do_add    = 1'b0;

    unique case (op_e'(in_q.operation))
      OP_ADD: begin
        do_add = 1'b1;
      end
      OP_UPDATE: begin
        if (match_hit) begin
          mounted_d[match_idx] = in_q.mounted;
          addr_d[match_idx]    = in_q.usb_addr;
          hid_d[match_idx]     = in_q.is_hid;
          proto_d[match_idx]   = in_q.hid_proto;
          if (cls > level_q[match_idx]) begin
            level_d[match_idx] = cls;
          end
          out_d.found        = 1'b1;
          out_d.risk_level   = level_d[match_idx];
          out_d.report_count = reports_q[match_idx];
        end else begin
          do_add = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (rm_hit) begin
          mounted_d[rm_idx] = 1'b0;
          addr_d[rm_idx]    = '0;
          hid_d[rm_idx]     = 1'b0;
          proto_d[rm_idx]   = '0;
          level_d[rm_idx]   = LVL_SAFE;
          reports_d[rm_idx] = '0;
          rate_d[rm_idx]    = '0;
          out_d.found       = 1'b1;
        end
      end
      OP_ACTIVITY: begin
        if (match_hit) begin
          reports_d[match_idx] = act_cnt;
          rate_d[match_idx]    = in_q.rate;
          hid_d[match_idx]     = act_hid;
          level_d[match_idx]   = act_lvl;
          out_d.found          = 1'b1;
          out_d.risk_level     = act_lvl;
          out_d.report_count   = act_cnt;
        end
      end
      OP_QUERY: begin
        if (match_hit) begin
          out_d.found        = 1'b1;
          out_d.risk_level   = level_q[match_idx];
          out_d.report_count = reports_q[match_idx];
        end
      end
      default: begin
        out_d = '0;
      end
    endcase

    // Take the first unmounted slot, or flag the table as full.
    if (do_add) begin
      if (free_hit) begin
        mounted_d[free_idx] = in_q.mounted;
        addr_d[free_idx]    = in_q.usb_addr;
        hid_d[free_idx]     = in_q.is_hid;
        proto_d[free_idx]   = in_q.hid_proto;
        level_d[free_idx]   = cls;
        reports_d[free_idx] = '0;
        rate_d[free_idx]    = '0;
        out_d.found         = 1'b1;
        out_d.risk_level    = cls;
      end else begin
        out_d.table_full = 1'b1;
      end
    end
  end

  `UDTT_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q)
  `UDTT_ASSERT_NEXT(a_stall_holds_req, in_valid_q && !advance, in_valid_q && $stable(in_q))
  `UDTT_ASSERT_IMPL(a_full_not_found, out_valid_q, !(out_q.table_full && out_q.found))
  `UDTT_ASSERT_IMPL(a_level_legal, out_valid_q, out_q.risk_level <= LVL_MALICIOUS)
  `UDTT_ASSERT_IMPL(a_full_only_on_add, advance && out_d.table_full,
                    !free_hit && ((in_q.operation == OP_ADD) || (in_q.operation == OP_UPDATE)))

endmodule
